// ===== hw/rtl/shuffled_lehmer_random_generator_defines.svh =====
// ----------------------------------------------------------------------------
// Shuffled Lehmer random generator: assertion macros
// Implication checks used by the file that carries assertions.
// ----------------------------------------------------------------------------
`ifndef SHUFFLED_LEHMER_RANDOM_GENERATOR_DEFINES_SVH
`define SHUFFLED_LEHMER_RANDOM_GENERATOR_DEFINES_SVH

// Same-cycle implication, gated by the active-low reset
`define SLRG_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, gated by the active-low reset
`define SLRG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/slrg_pkg.sv =====
// ----------------------------------------------------------------------------
// slrg_pkg
// Constants and small arithmetic helpers of the shuffled Lehmer generator.
// ----------------------------------------------------------------------------
`default_nettype none

package slrg_pkg;

  // Generator arithmetic
  localparam int unsigned ValW     = 31;
  localparam int unsigned MulW     = 15;
  localparam int unsigned ProdW    = ValW + MulW;
  localparam logic [MulW-1:0] LehMul = MulW'(16807);
  localparam logic [ValW-1:0] LehMod = 31'h7FFF_FFFF;

  // Shuffle table
  localparam int unsigned TableDepth = 32;
  localparam int unsigned TblAw      = $clog2(TableDepth);
  localparam int unsigned InitSteps  = TableDepth + 8;
  localparam int unsigned CntW       = $clog2(InitSteps);

  // Result fraction
  localparam int unsigned FracW   = 24;
  localparam logic [FracW-1:0] FracMax = 24'd16777213;

  // Stream widths
  localparam int unsigned InTdataW  = 8;
  localparam int unsigned OutTdataW = ((ValW + FracW + 7) / 8) * 8;

  // Replace a seed that would lock the generator at zero
  function automatic logic [ValW-1:0] seed_fix(input logic [ValW-1:0] s);
    logic [ValW-1:0] r;
    r = s;
    if (s == '0 || s == LehMod) begin
      r = ValW'(1);
    end
    return r;
  endfunction

  // Slot = floor(TableDepth * held / (2^31 - 2 + TableDepth)), exact
  function automatic logic [TblAw-1:0] slot_of(input logic [ValW-1:0] held);
    localparam int unsigned SpW = ValW + TblAw;
    localparam int unsigned CrW = 2 * TblAw + 1;
    logic [SpW-1:0]   p;
    logic [TblAw-1:0] q0;
    logic [CrW-1:0]   corr;
    logic [TblAw-1:0] q;
    p    = SpW'(held) * SpW'(TableDepth);
    q0   = p[SpW-1:ValW];
    corr = CrW'(q0) * CrW'(TableDepth - 2);
    q    = q0;
    if (p[ValW-1:0] < ValW'(corr)) begin
      q = q0 - TblAw'(1);
    end
    return q;
  endfunction

  // floor(v * 2^24 / (2^31 - 1)), clamped just below one
  function automatic logic [FracW-1:0] frac_of(input logic [ValW-1:0] v);
    logic [FracW-1:0] a;
    logic [ValW-1:0]  b;
    logic [ValW:0]    s;
    logic [FracW:0]   q;
    a = v[ValW-1:ValW-FracW];
    b = {v[ValW-FracW-1:0], {FracW{1'b0}}};
    s = (ValW+1)'(a) + (ValW+1)'(b);
    q = (FracW+1)'(a) + (FracW+1)'(s >= (ValW+1)'(LehMod));
    if (q > (FracW+1)'(FracMax)) begin
      q = (FracW+1)'(FracMax);
    end
    return q[FracW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/slrg_lehmer_unit.sv =====
// ----------------------------------------------------------------------------
// slrg_lehmer_unit
// Shared Lehmer step x * 16807 mod (2^31 - 1): a registered multiply
// followed by a Mersenne fold in the next cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module slrg_lehmer_unit (
  input  wire                          clk_i,
  input  wire                          mul_en_i,
  input  wire  [slrg_pkg::ValW-1:0]    x_i,
  output logic [slrg_pkg::ValW-1:0]    y_o
);
  import slrg_pkg::*;

  logic [ProdW-1:0] prod_q;
  logic [ValW:0]    sum;

  // Capture the product
  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_q <= ProdW'(x_i) * ProdW'(LehMul);
    end
  end

  // Fold high part onto low part, one conditional subtract
  always_comb begin
    sum = (ValW+1)'(prod_q[ValW-1:0]) + (ValW+1)'(prod_q[ProdW-1:ValW]);
    if (sum >= (ValW+1)'(LehMod)) begin
      sum = sum - (ValW+1)'(LehMod);
    end
    y_o = sum[ValW-1:0];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/slrg_table.sv =====
// ----------------------------------------------------------------------------
// slrg_table
// Shuffle table: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module slrg_table (
  input  wire                          clk_i,
  input  wire                          wr_en_i,
  input  wire  [slrg_pkg::TblAw-1:0]   wr_addr_i,
  input  wire  [slrg_pkg::ValW-1:0]    wr_data_i,
  input  wire  [slrg_pkg::TblAw-1:0]   rd_addr_i,
  output logic [slrg_pkg::ValW-1:0]    rd_data_o
);
  import slrg_pkg::*;

  logic [ValW-1:0] mem [TableDepth];
  logic [ValW-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, every cycle
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== hw/rtl/shuffled_lehmer_random_generator.sv =====
// ----------------------------------------------------------------------------
// shuffled_lehmer_random_generator: a draw runs from accept through a multiply
// state, then fold + table swap, which waits for a free output register; no new
// request is taken until the draw is done. An initialization adds 40 shared
// Lehmer steps, each a multiply state and then a fold state.
// Reset arms initialization, seed resets to 1; output register comes up empty.
`default_nettype none
`include "shuffled_lehmer_random_generator_defines.svh"

module shuffled_lehmer_random_generator (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // Seed register write
  input  wire                               cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire  [slrg_pkg::ValW-1:0]         cfg_data_i,
  // Requests
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire  [slrg_pkg::InTdataW-1:0]     s_axis_tdata,   // [0] restart
  // Results
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  output logic [slrg_pkg::OutTdataW-1:0]    m_axis_tdata    // [30:0] sample, [54:31] fraction
);
  import slrg_pkg::*;

  localparam int unsigned StW = 3;
  localparam logic [StW-1:0] ST_IDLE      = 3'd0;
  localparam logic [StW-1:0] ST_INIT_MUL  = 3'd1;
  localparam logic [StW-1:0] ST_INIT_FOLD = 3'd2;
  localparam logic [StW-1:0] ST_DRAW_MUL  = 3'd3;
  localparam logic [StW-1:0] ST_DRAW_FOLD = 3'd4;

  logic [StW-1:0]   st_q, st_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [ValW-1:0]  seed_q;
  logic             needs_init_q, needs_init_d;
  logic [ValW-1:0]  lstate_q, lstate_d;
  logic [ValW-1:0]  held_q, held_d;
  logic             out_valid_q, out_valid_d;
  logic [ValW-1:0]  sample_q;
  logic [FracW-1:0] frac_q;
  logic             out_load;

  logic             in_xact;
  logic             cfg_xact;
  logic             mul_en;
  logic [ValW-1:0]  fold_y;
  logic [TblAw-1:0] slot;
  logic             wr_en;
  logic [TblAw-1:0] wr_addr;
  logic [TblAw-1:0] rd_addr;
  logic [ValW-1:0]  rd_data;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (st_q == ST_IDLE);
  assign in_xact       = s_axis_tvalid & s_axis_tready;
  assign cfg_xact      = cfg_valid_i & cfg_ready_o;
  assign slot          = slot_of(held_q);
  assign rd_addr       = slot;

  // Shared Lehmer step
  slrg_lehmer_unit u_lehmer (
    .clk_i    (clk_i),
    .mul_en_i (mul_en),
    .x_i      (lstate_q),
    .y_o      (fold_y)
  );

  // Shuffle table
  slrg_table u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (fold_y),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Sequencer
  always_comb begin
    st_d         = st_q;
    cnt_d        = cnt_q;
    lstate_d     = lstate_q;
    held_d       = held_q;
    needs_init_d = needs_init_q;
    mul_en       = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = slot;
    out_load     = 1'b0;

    case (st_q)
      ST_IDLE: begin
        if (in_xact) begin
          if (needs_init_q || s_axis_tdata[0]) begin
            lstate_d = seed_fix(seed_q);
            cnt_d    = CntW'(InitSteps - 1);
            st_d     = ST_INIT_MUL;
          end else begin
            st_d = ST_DRAW_MUL;
          end
        end
      end
      ST_INIT_MUL: begin
        mul_en = 1'b1;
        st_d   = ST_INIT_FOLD;
      end
      ST_INIT_FOLD: begin
        lstate_d = fold_y;
        // Keep the last TableDepth steps, entry 0 last
        if (cnt_q < CntW'(TableDepth)) begin
          wr_en   = 1'b1;
          wr_addr = cnt_q[TblAw-1:0];
        end
        if (cnt_q == '0) begin
          held_d       = fold_y;
          needs_init_d = 1'b0;
          st_d         = ST_DRAW_MUL;
        end else begin
          cnt_d = cnt_q - CntW'(1);
          st_d  = ST_INIT_MUL;
        end
      end
      ST_DRAW_MUL: begin
        mul_en = 1'b1;
        st_d   = ST_DRAW_FOLD;
      end
      ST_DRAW_FOLD: begin
        // Swap only once the output register is free
        if (!out_valid_q || m_axis_tready) begin
          lstate_d = fold_y;
          wr_en    = 1'b1;
          held_d   = rd_data;
          out_load = 1'b1;
          st_d     = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase

    // Seed write arms reinitialization
    if (cfg_xact) begin
      needs_init_d = 1'b1;
    end
  end

  // Output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tvalid && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= ST_IDLE;
      cnt_q        <= '0;
      seed_q       <= ValW'(1);
      needs_init_q <= 1'b1;
      lstate_q     <= '0;
      held_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      st_q         <= st_d;
      cnt_q        <= cnt_d;
      needs_init_q <= needs_init_d;
      lstate_q     <= lstate_d;
      held_q       <= held_d;
      out_valid_q  <= out_valid_d;
      if (cfg_xact) begin
        seed_q <= cfg_data_i;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      sample_q <= rd_data;
      frac_q   <= frac_of(rd_data);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutTdataW - ValW - FracW){1'b0}}, frac_q, sample_q};

  // Checks
  `SLRG_ASSERT_IMPL(a_sample_nonzero, clk_i, rst_ni, m_axis_tvalid, sample_q != '0, "sample is zero")
  `SLRG_ASSERT_IMPL(a_frac_clamped, clk_i, rst_ni, m_axis_tvalid, frac_q <= FracMax, "fraction above clamp")
  `SLRG_ASSERT_NEXT(a_restart_inits, clk_i, rst_ni, in_xact && s_axis_tdata[0], st_q == ST_INIT_MUL, "restart did not start initialization")

endmodule

`default_nettype wire

// ===== dv/shuffled_lehmer_random_generator_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Shuffled Lehmer generator checker
// Watches the seed channel and both streams, keeps its own copy of the
// generator and shuffle table, predicts every draw and compares each result
// field by field against the oldest predicted draw.
// ----------------------------------------------------------------------------
module shuffled_lehmer_random_generator_checker
  import slrg_pkg::*;
(
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_valid_i,
  input  wire                  cfg_ready_i,
  input  wire  [ValW-1:0]      cfg_data_i,
  input  wire                  req_valid_i,
  input  wire                  req_ready_i,
  input  wire  [InTdataW-1:0]  req_data_i,   // [0] restart
  input  wire                  res_valid_i,
  input  wire                  res_ready_i,
  input  wire  [OutTdataW-1:0] res_data_i,   // [30:0] sample, [54:31] fraction
  output int                   fail_count_o,
  output int                   pending_o
);

  localparam longint unsigned ModulusL  = 64'd2147483647;
  localparam longint unsigned SlotDiv   = 64'd2147483646 + TableDepth;

  typedef struct packed {
    logic [ValW-1:0]  sample;
    logic [FracW-1:0] fraction;
  } draw_t;

  draw_t           expected_draws[$];
  logic [ValW-1:0] seed_q;
  logic [ValW-1:0] lehmer_q;
  logic [ValW-1:0] held_q;
  logic [ValW-1:0] shuffle_q[TableDepth];
  logic            armed_q;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  // One line per mismatch, and count it
  task report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    fail_count_o++;
  endtask

  // Multiply by 16807 modulo 2^31 - 1
  function automatic logic [ValW-1:0] lehmer_advance(input logic [ValW-1:0] x);
    longint unsigned p;
    p = x;
    p = (p * 64'd16807) % ModulusL;
    return p[ValW-1:0];
  endfunction

  // Warm up from the seed and refill the shuffle table, entry 0 last
  task refill_table();
    logic [ValW-1:0] x;
    int              i;
    x = seed_q;
    if (x == '0 || x == LehMod) begin
      x = ValW'(1);
    end
    for (i = InitSteps - 1; i >= 0; i--) begin
      x = lehmer_advance(x);
      if (i < TableDepth) begin
        shuffle_q[i] = x;
      end
    end
    lehmer_q = x;
    held_q   = shuffle_q[0];
    armed_q  = 1'b0;
  endtask

  // Refill if armed or on restart; advance, slot from held value, swap, queue
  task predict_draw(input logic restart);
    longint unsigned num;
    longint unsigned slot;
    longint unsigned frac;
    draw_t           d;
    if (armed_q || restart) begin
      refill_table();
    end
    lehmer_q = lehmer_advance(lehmer_q);
    num  = held_q;
    slot = (num * TableDepth) / SlotDiv;
    if (slot >= TableDepth) begin
      slot = TableDepth - 1;
    end
    held_q          = shuffle_q[slot];
    shuffle_q[slot] = lehmer_q;
    num  = held_q;
    frac = (num << FracW) / ModulusL;
    if (frac > FracMax) begin
      frac = FracMax;
    end
    d.sample   = held_q;
    d.fraction = frac[FracW-1:0];
    expected_draws.push_back(d);
  endtask

  // Compare one accepted result with the oldest predicted draw
  task check_result(input logic [OutTdataW-1:0] data);
    draw_t            d;
    logic [ValW-1:0]  got_sample;
    logic [FracW-1:0] got_frac;
    got_sample = data[ValW-1:0];
    got_frac   = data[ValW+FracW-1:ValW];
    if (expected_draws.size() == 0) begin
      report_mismatch($sformatf("result with nothing expected: sample %0d fraction %0d",
                                got_sample, got_frac));
    end else begin
      d = expected_draws.pop_front();
      if (got_sample !== d.sample) begin
        report_mismatch($sformatf("sample got %0d expected %0d", got_sample, d.sample));
      end
      if (got_frac !== d.fraction) begin
        report_mismatch($sformatf("fraction got %0d expected %0d (sample %0d)",
                                  got_frac, d.fraction, d.sample));
      end
    end
  endtask

  // Track seed writes, requests and results in transaction order
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q   = ValW'(1);
      lehmer_q = '0;
      held_q   = '0;
      armed_q  = 1'b1;
      for (int i = 0; i < TableDepth; i++) begin
        shuffle_q[i] = '0;
      end
      expected_draws.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        seed_q  = cfg_data_i;
        armed_q = 1'b1;
      end
      if (req_valid_i && req_ready_i) begin
        predict_draw(req_data_i[0]);
      end
      if (res_valid_i && res_ready_i) begin
        check_result(res_data_i);
      end
    end
    pending_o = expected_draws.size();
  end

endmodule

// ===== dv/tb_shuffled_lehmer_random_generator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Shuffled Lehmer generator testbench
// Drives draw requests and seed writes with random gaps and result stalls,
// covering out-of-range seeds, restarts and many seeds; the checker beside
// the block predicts and compares every draw.
// ----------------------------------------------------------------------------
module tb_shuffled_lehmer_random_generator;
  import slrg_pkg::*;

  localparam int unsigned RunLimit    = 1_000_000;
  localparam int unsigned RandomItems = 1300;
  localparam int unsigned SeedPhases  = 6;
  localparam int unsigned BurstSpan   = 40;
  localparam int unsigned DrainCycles = 30;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [ValW-1:0]      cfg_data = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata = '0;    // [0] restart
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;         // [30:0] sample, [54:31] fraction

  int          fail_count;
  int          pending;
  int unsigned cycle_count = 0;
  logic        result_taken = 1'b0;
  logic        quiet_src = 1'b0;
  logic        quiet_snk = 1'b0;
  int unsigned stall_left = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  shuffled_lehmer_random_generator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  shuffled_lehmer_random_generator_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_i  (s_axis_tready),
    .req_data_i   (s_axis_tdata),
    .res_valid_i  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_data_i   (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Give up on a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RunLimit) begin
      $display("shuffled_lehmer_random_generator test failed");
      $finish;
    end
  end

  // Result side: after each transaction, hold ready low for a drawn stall
  always @(posedge clk_i) begin
    result_taken <= m_axis_tvalid && m_axis_tready;
  end

  always @(negedge clk_i) begin
    if (result_taken) begin
      stall_left = quiet_snk ? 0 : $urandom_range(0, 19);
    end
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Request one draw after a drawn gap; valid stays up when the gap is zero
  task automatic send_draw(input logic restart);
    int unsigned gap;
    gap = quiet_src ? 0 : $urandom_range(0, 19);
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = InTdataW'(restart);
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Write the seed once every predicted draw has come back
  task automatic write_seed(input logic [ValW-1:0] value);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  // Mostly ordinary seeds, now and then an extreme one
  function automatic logic [ValW-1:0] pick_seed();
    logic [ValW-1:0] s;
    case ($urandom_range(0, 9))
      0:       s = '0;
      1:       s = LehMod;
      2:       s = ValW'(1);
      3:       s = LehMod - ValW'(1);
      default: s = ValW'($urandom_range(1, 32'd2147483646));
    endcase
    return s;
  endfunction

  initial begin
    int unsigned per_phase;
    per_phase = RandomItems / SeedPhases;

    // Reset once at the start
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset seed: plain draws, a restart, then restarts back to back
    repeat (4) send_draw(1'b0);
    send_draw(1'b1);
    repeat (3) send_draw(1'b0);
    send_draw(1'b1);
    send_draw(1'b1);
    send_draw(1'b0);

    // Out-of-range seeds fall back to one
    write_seed('0);
    repeat (3) send_draw(1'b0);
    write_seed(LehMod);
    send_draw(1'b0);
    send_draw(1'b1);

    // Extremes of the valid seed range
    write_seed(LehMod - ValW'(1));
    send_draw(1'b0);
    send_draw(1'b1);
    send_draw(1'b0);
    write_seed(ValW'(1));
    repeat (2) send_draw(1'b0);

    // Random phases, one seed each, with stretches of back-to-back traffic
    for (int p = 0; p < SeedPhases; p++) begin
      write_seed(pick_seed());
      for (int n = 0; n < per_phase; n++) begin
        if (n % BurstSpan == 0) begin
          quiet_src = ($urandom_range(0, 3) == 0);
          quiet_snk = ($urandom_range(0, 3) == 0);
        end
        send_draw($urandom_range(0, 19) == 0);
      end
    end

    // Drain and let any stray result show up
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    quiet_snk = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    if (fail_count == 0) begin
      $display("shuffled_lehmer_random_generator test passed");
    end else begin
      $display("shuffled_lehmer_random_generator test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/slrg_pkg.sv
hw/rtl/slrg_lehmer_unit.sv
hw/rtl/slrg_table.sv
hw/rtl/shuffled_lehmer_random_generator.sv
dv/shuffled_lehmer_random_generator_checker.sv
dv/tb_shuffled_lehmer_random_generator.sv
